@@ rtl/gmeu_pkg.sv @@
// Shared types, constants and helpers for the gravity momentum/energy update block.
package gmeu_pkg;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_USE_POT   = 3'd0;
  localparam logic [2:0] REG_FIVE_PT   = 3'd1;
  localparam logic [2:0] REG_EXT_EN    = 3'd2;
  localparam logic [2:0] REG_TIME_STEP = 3'd3;
  localparam logic [2:0] REG_GRAD_COEF = 3'd4;

  // Sequencer step limits
  localparam logic [4:0] READ_LAST = 5'd12;
  localparam logic [4:0] MUL_LAST  = 5'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX1,
    ST_IDX2,
    ST_BASE,
    ST_READ,
    ST_WDIV,
    ST_MUL,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [3:0] {
    MUL_NOP,
    MUL_EXT,
    MUL_GRAD,
    MUL_SQ_IN,
    MUL_RHO,
    MUL_KLO_IN,
    MUL_KHI_IN,
    MUL_SQ_OUT,
    MUL_KLO_OUT,
    MUL_KHI_OUT
  } mul_op_e;

  typedef struct packed {
    mul_op_e    op;
    logic [1:0] axis;
  } mul_cmd_t;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       idx1;
    logic       idx2;
    logic       base;
    logic       rd_en;
    logic [3:0] rd_step;
    mul_cmd_t   mul;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -68'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Multiplier schedule: each op is written back in the cycle after issue.
  function automatic mul_cmd_t mul_sched(input logic [4:0] step);
    mul_cmd_t c;
    c.op   = MUL_NOP;
    c.axis = 2'd0;
    unique case (step)
      5'd0:  begin c.op = MUL_EXT;     c.axis = 2'd0; end
      5'd1:  begin c.op = MUL_GRAD;    c.axis = 2'd0; end
      5'd2:  begin c.op = MUL_EXT;     c.axis = 2'd1; end
      5'd3:  begin c.op = MUL_GRAD;    c.axis = 2'd1; end
      5'd4:  begin c.op = MUL_EXT;     c.axis = 2'd2; end
      5'd5:  begin c.op = MUL_GRAD;    c.axis = 2'd2; end
      5'd6:  begin c.op = MUL_SQ_IN;   c.axis = 2'd0; end
      5'd7:  begin c.op = MUL_SQ_IN;   c.axis = 2'd1; end
      5'd8:  begin c.op = MUL_SQ_IN;   c.axis = 2'd2; end
      5'd9:  begin c.op = MUL_RHO;     c.axis = 2'd0; end
      5'd10: begin c.op = MUL_RHO;     c.axis = 2'd1; end
      5'd11: begin c.op = MUL_RHO;     c.axis = 2'd2; end
      5'd12: begin c.op = MUL_KLO_IN;  c.axis = 2'd0; end
      5'd13: begin c.op = MUL_KHI_IN;  c.axis = 2'd0; end
      5'd14: begin c.op = MUL_SQ_OUT;  c.axis = 2'd0; end
      5'd15: begin c.op = MUL_SQ_OUT;  c.axis = 2'd1; end
      5'd16: begin c.op = MUL_SQ_OUT;  c.axis = 2'd2; end
      5'd18: begin c.op = MUL_KLO_OUT; c.axis = 2'd0; end
      5'd19: begin c.op = MUL_KHI_OUT; c.axis = 2'd0; end
      default: begin c.op = MUL_NOP;   c.axis = 2'd0; end
    endcase
    return c;
  endfunction

endpackage

@@ rtl/gmeu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gmeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1728
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/gmeu_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module gmeu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [30:0] dvs_q, dvs_d;
  logic [31:0] rem_sh;
  logic [32:0] rem_sub;

  always_comb begin
    rem_sh  = {rem_q[30:0], quo_q[31]};
    rem_sub = {1'b0, rem_sh} - {2'b0, dvs_q};
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d = 6'd32;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!rem_sub[32]) begin
        rem_d = rem_sub[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = quo_q;

endmodule

@@ rtl/gmeu_ctrl.sv @@
// Sequencer for the update: index split, stencil reads, multiply schedule, result hand-off.
module gmeu_ctrl
  import gmeu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       func_i,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;
  logic        out_free;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = 5'd0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && func_i) begin
          state_d = ST_IDX1;
        end
      end
      ST_IDX1: state_d = ST_IDX2;
      ST_IDX2: state_d = ST_BASE;
      ST_BASE: state_d = ST_READ;
      ST_READ: begin
        if (cnt_q == READ_LAST) begin
          state_d = ST_WDIV;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_WDIV: begin
        if (status_i.div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == MUL_LAST) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul.op   = MUL_NOP;
    cmd_o.load     = in_accept && !func_i;
    cmd_o.capture  = in_accept && func_i;
    cmd_o.idx1     = (state_q == ST_IDX1);
    cmd_o.idx2     = (state_q == ST_IDX2);
    cmd_o.base     = (state_q == ST_BASE);
    cmd_o.rd_en    = (state_q == ST_READ) && (cnt_q != READ_LAST);
    cmd_o.rd_step  = cnt_q[3:0];
    if ((state_q == ST_MUL) && (cnt_q != MUL_LAST)) begin
      cmd_o.mul = mul_sched(cnt_q);
    end
    cmd_o.finish   = (state_q == ST_DONE) && out_free;
  end

  // Set on hand-off, drop once the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/gmeu_dp.sv @@
// Datapath: potential store, stencil accumulation, shared multiplier, divider and result register.
module gmeu_dp
  import gmeu_pkg::*;
#(
  parameter int PATCH_SIZE = 8,
  parameter int GHOST_SIZE = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic               use_pot_i,
  input  logic               five_point_i,
  input  logic               ext_acc_en_i,
  input  logic signed [31:0] time_step_i,
  input  logic signed [31:0] grad_coef_i,
  input  logic [10:0]        pot_addr_i,
  input  logic signed [31:0] pot_value_i,
  input  logic [8:0]         cell_index_i,
  input  logic [30:0]        density_i,
  input  logic signed [31:0] mom_x_in_i,
  input  logic signed [31:0] mom_y_in_i,
  input  logic signed [31:0] mom_z_in_i,
  input  logic signed [31:0] energy_in_i,
  input  logic signed [31:0] ext_acc_x_i,
  input  logic signed [31:0] ext_acc_y_i,
  input  logic signed [31:0] ext_acc_z_i,
  output logic [8:0]         cell_out_o,
  output logic signed [31:0] mom_x_out_o,
  output logic signed [31:0] mom_y_out_o,
  output logic signed [31:0] mom_z_out_o,
  output logic signed [31:0] energy_out_o
);

  localparam int NXT      = PATCH_SIZE + 2 * GHOST_SIZE;
  localparam int STRIDE_Z = NXT * NXT;
  localparam int DEPTH    = NXT * NXT * NXT;
  localparam int AW       = $clog2(DEPTH);
  localparam int CELLS    = PATCH_SIZE * PATCH_SIZE * PATCH_SIZE;
  localparam int CIW      = $clog2(CELLS);
  localparam int CW       = $clog2(PATCH_SIZE);
  localparam int Q1W      = $clog2(PATCH_SIZE * PATCH_SIZE);
  localparam int XW       = $clog2(NXT + 1);
  localparam int RS       = 24;
  localparam int RM       = (1 << RS) / PATCH_SIZE + 1;
  localparam int RMW      = $clog2(RM + 1);
  localparam int M1W      = CIW + RMW;
  localparam int M2W      = Q1W + RMW;
  localparam int GOFF     = GHOST_SIZE * (STRIDE_Z + NXT + 1);
  localparam logic [12:0] CELLS_W = 13'(CELLS);

  // ---------------- item capture and index split ----------------
  logic [8:0]         cell_q;
  logic [30:0]        rho_q;
  logic signed [31:0] pin_q  [3];
  logic signed [31:0] ext_q  [3];
  logic signed [31:0] energy_q;
  logic [CIW-1:0]     ci_q;
  logic [CW-1:0]      cx_q, cy_q, cz_q;
  logic [Q1W-1:0]     q1_q;
  logic [AW-1:0]      base_q;
  logic [12:0]        ci_mod;
  logic [M1W-1:0]     dprod1;
  logic [M2W-1:0]     dprod2;
  logic [Q1W-1:0]     q1;
  logic [CW-1:0]      r1, q2, r2;

  // Fold the cell index into the patch
  always_comb begin
    ci_mod = {4'b0, cell_index_i};
    for (int k = 0; k < 8; k++) begin
      if (ci_mod >= CELLS_W) begin
        ci_mod = ci_mod - CELLS_W;
      end
    end
  end

  // Divide by the patch size through a reciprocal multiply
  assign dprod1 = M1W'(ci_q) * M1W'(RM);
  assign q1     = Q1W'(dprod1 >> RS);
  assign r1     = CW'(ci_q - CIW'(q1) * CIW'(PATCH_SIZE));
  assign dprod2 = M2W'(q1_q) * M2W'(RM);
  assign q2     = CW'(dprod2 >> RS);
  assign r2     = CW'(q1_q - Q1W'(q2) * Q1W'(PATCH_SIZE));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cell_q   <= cell_index_i;
      rho_q    <= density_i;
      pin_q[0] <= mom_x_in_i;
      pin_q[1] <= mom_y_in_i;
      pin_q[2] <= mom_z_in_i;
      ext_q[0] <= ext_acc_x_i;
      ext_q[1] <= ext_acc_y_i;
      ext_q[2] <= ext_acc_z_i;
      energy_q <= energy_in_i;
      ci_q     <= CIW'(ci_mod);
    end
    if (cmd_i.idx1) begin
      cx_q <= r1;
      q1_q <= q1;
    end
    if (cmd_i.idx2) begin
      cy_q <= r2;
      cz_q <= q2;
    end
    if (cmd_i.base) begin
      base_q <= AW'(32'(cz_q) * 32'(STRIDE_Z) + 32'(cy_q) * 32'(NXT) + 32'(cx_q)
                    + 32'(GOFF));
    end
  end

  // ---------------- stencil reads ----------------
  logic [1:0]     rd_ax, rd_term;
  logic [XW-1:0]  rd_c, rd_k;
  logic [AW-1:0]  rd_stride, rd_offs, rd_addr;
  logic           rd_up, rd_inb;
  logic           rv_q, rinb_q;
  logic [1:0]     rax_q, rterm_q;
  logic [31:0]    ram_rdata;
  logic           ram_we;
  logic signed [36:0] rd_val, rd_w;
  logic signed [36:0] diff_q [3];

  always_comb begin
    rd_ax   = cmd_i.rd_step[3:2];
    rd_term = cmd_i.rd_step[1:0];
    unique case (rd_ax)
      2'd0: begin
        rd_c      = XW'(cx_q);
        rd_stride = AW'(1);
      end
      2'd1: begin
        rd_c      = XW'(cy_q);
        rd_stride = AW'(NXT);
      end
      default: begin
        rd_c      = XW'(cz_q);
        rd_stride = AW'(STRIDE_Z);
      end
    endcase
    rd_k    = rd_term[1] ? XW'(2) : XW'(1);
    rd_up   = !rd_term[0];
    rd_inb  = rd_up ? ((rd_c + rd_k) < XW'(PATCH_SIZE + GHOST_SIZE))
                    : ((rd_c + XW'(GHOST_SIZE)) >= rd_k);
    rd_offs = rd_term[1] ? (rd_stride << 1) : rd_stride;
    rd_addr = rd_up ? (base_q + rd_offs) : (base_q - rd_offs);
  end

  assign ram_we = cmd_i.load && ({{AW{1'b0}}, pot_addr_i} < (AW + 11)'(DEPTH));

  gmeu_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_pot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(pot_addr_i)),
    .wdata_i (pot_value_i),
    .re_i    (cmd_i.rd_en && rd_inb),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Weight the neighbor: 5-point is -P2 + 8P1 - 8M1 + M2, 2-point is P1 - M1
  always_comb begin
    rd_val = rinb_q ? 37'($signed(ram_rdata)) : 37'sd0;
    unique case (rterm_q)
      2'd0:    rd_w = five_point_i ? (rd_val <<< 3) : rd_val;
      2'd1:    rd_w = five_point_i ? -(rd_val <<< 3) : -rd_val;
      2'd2:    rd_w = five_point_i ? -rd_val : 37'sd0;
      default: rd_w = five_point_i ? rd_val : 37'sd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rinb_q  <= rd_inb;
    rax_q   <= rd_ax;
    rterm_q <= rd_term;
    if (cmd_i.capture) begin
      diff_q[0] <= '0;
      diff_q[1] <= '0;
      diff_q[2] <= '0;
    end else if (rv_q) begin
      unique case (rax_q)
        2'd0:    diff_q[0] <= diff_q[0] + rd_w;
        2'd1:    diff_q[1] <= diff_q[1] + rd_w;
        default: diff_q[2] <= diff_q[2] + rd_w;
      endcase
    end
  end

  // ---------------- 0.5/rho ----------------
  logic        div_busy;
  logic [31:0] div_quot;
  logic [30:0] half_inv;

  gmeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.capture),
    .dividend_i (32'h8000_0000 + {2'b0, density_i[30:1]}),
    .divisor_i  (density_i),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_comb begin
    if ((rho_q == 31'd0) || div_quot[31]) begin
      half_inv = 31'h7FFF_FFFF;
    end else begin
      half_inv = div_quot[30:0];
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.div_done = !div_busy;

  // ---------------- shared multiplier ----------------
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_q;
  mul_op_e            wop_q;
  logic [1:0]         wax_q;
  logic signed [31:0] acc_q  [3];
  logic signed [31:0] pout_q [3];
  logic [63:0]        s_in_q, s_out_q;
  logic [31:0]        kacc_q;
  logic [30:0]        ek_in_q;
  logic signed [31:0] e_res_q;
  logic signed [65:0] qr;
  logic [63:0]        kin_sum;
  logic [30:0]        ek_now;
  logic [63:0]        klo;
  logic signed [67:0] e_sum;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.mul.op)
      MUL_EXT: begin
        ma = 33'(time_step_i);
        mb = 33'(ext_q[cmd_i.mul.axis]);
      end
      MUL_GRAD: begin
        ma = 33'(grad_coef_i);
        mb = 33'(sat32(68'(diff_q[cmd_i.mul.axis])));
      end
      MUL_SQ_IN: begin
        ma = 33'(pin_q[cmd_i.mul.axis]);
        mb = 33'(pin_q[cmd_i.mul.axis]);
      end
      MUL_RHO: begin
        ma = $signed({2'b0, rho_q});
        mb = 33'(acc_q[cmd_i.mul.axis]);
      end
      MUL_KLO_IN: begin
        ma = $signed({1'b0, s_in_q[31:0]});
        mb = $signed({2'b0, half_inv});
      end
      MUL_KHI_IN: begin
        ma = $signed({1'b0, s_in_q[63:32]});
        mb = $signed({2'b0, half_inv});
      end
      MUL_SQ_OUT: begin
        ma = 33'(pout_q[cmd_i.mul.axis]);
        mb = 33'(pout_q[cmd_i.mul.axis]);
      end
      MUL_KLO_OUT: begin
        ma = $signed({1'b0, s_out_q[31:0]});
        mb = $signed({2'b0, half_inv});
      end
      MUL_KHI_OUT: begin
        ma = $signed({1'b0, s_out_q[63:32]});
        mb = $signed({2'b0, half_inv});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wop_q <= MUL_NOP;
    end else begin
      wop_q <= cmd_i.mul.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    wax_q  <= cmd_i.mul.axis;
  end

  // Write-back arithmetic: round to nearest, ties up; kinetic terms saturate high
  always_comb begin
    qr      = (prod_q + 66'sd32768) >>> 16;
    klo     = (prod_q[63:0] + 64'h8000_0000) >> 32;
    kin_sum = prod_q[63:0] + {32'b0, kacc_q};
    ek_now  = (kin_sum[63:31] != '0) ? 31'h7FFF_FFFF : kin_sum[30:0];
    e_sum   = 68'(energy_q) - 68'($signed({1'b0, ek_in_q}))
              + 68'($signed({1'b0, ek_now}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_in_q  <= '0;
      s_out_q <= '0;
    end else begin
      unique case (wop_q)
        MUL_EXT: begin
          acc_q[wax_q] <= ext_acc_en_i ? sat32(68'(qr)) : 32'sd0;
        end
        MUL_GRAD: begin
          if (use_pot_i) begin
            acc_q[wax_q] <= sat32(68'(acc_q[wax_q]) + 68'(sat32(68'(qr))));
          end
        end
        MUL_SQ_IN:   s_in_q <= s_in_q + prod_q[63:0];
        MUL_RHO:     pout_q[wax_q] <= sat32(68'(pin_q[wax_q]) + 68'(qr));
        MUL_KLO_IN:  kacc_q <= klo[31:0];
        MUL_KHI_IN:  ek_in_q <= ek_now;
        MUL_SQ_OUT:  s_out_q <= s_out_q + prod_q[63:0];
        MUL_KLO_OUT: kacc_q <= klo[31:0];
        MUL_KHI_OUT: e_res_q <= sat32(e_sum);
        default: begin
        end
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cell_out_o   <= cell_q;
      mom_x_out_o  <= pout_q[0];
      mom_y_out_o  <= pout_q[1];
      mom_z_out_o  <= pout_q[2];
      energy_out_o <= e_res_q;
    end
  end

endmodule

@@ rtl/gravity_momentum_energy_update.sv @@
// Top level of the gravity momentum/energy update: configuration registers, sequencer, datapath.
//
// Load items (func_i = 0) write one potential word and leave the input side open. A cell
// item holds the input side from acceptance to hand-off: the 32-step serial divider that
// forms 0.5/rho goes first (index split and the twelve stencil reads from the single
// potential RAM port run under it), then the one shared 33x33 multiplier forms the
// acceleration, momentum and kinetic-energy products, and the item goes to the output
// register once that register is free. The finished item waits there while the next
// item is taken. The potential store is not cleared by reset; read only written entries.
module gravity_momentum_energy_update
  import gmeu_pkg::*;
#(
  parameter int PATCH_SIZE = 8,
  parameter int GHOST_SIZE = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [10:0]        pot_addr_i,
  input  logic signed [31:0] pot_value_i,
  input  logic [8:0]         cell_index_i,
  input  logic [30:0]        density_i,
  input  logic signed [31:0] mom_x_in_i,
  input  logic signed [31:0] mom_y_in_i,
  input  logic signed [31:0] mom_z_in_i,
  input  logic signed [31:0] energy_in_i,
  input  logic signed [31:0] ext_acc_x_i,
  input  logic signed [31:0] ext_acc_y_i,
  input  logic signed [31:0] ext_acc_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [8:0]         cell_out_o,
  output logic signed [31:0] mom_x_out_o,
  output logic signed [31:0] mom_y_out_o,
  output logic signed [31:0] mom_z_out_o,
  output logic signed [31:0] energy_out_o
);

  logic               use_pot_q;
  logic               five_pt_q;
  logic               ext_en_q;
  logic signed [31:0] time_step_q;
  logic signed [31:0] grad_coef_q;
  logic [2:0]         reg_idx;
  logic               cfg_wr;
  dp_cmd_t            dp_cmd;
  dp_status_t         dp_status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_pot_q   <= 1'b1;
      five_pt_q   <= 1'b0;
      ext_en_q    <= 1'b0;
      time_step_q <= '0;
      grad_coef_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_USE_POT:   use_pot_q   <= pwdata[0];
        REG_FIVE_PT:   five_pt_q   <= pwdata[0];
        REG_EXT_EN:    ext_en_q    <= pwdata[0];
        REG_TIME_STEP: time_step_q <= pwdata;
        REG_GRAD_COEF: grad_coef_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_USE_POT:   prdata = {31'b0, use_pot_q};
      REG_FIVE_PT:   prdata = {31'b0, five_pt_q};
      REG_EXT_EN:    prdata = {31'b0, ext_en_q};
      REG_TIME_STEP: prdata = time_step_q;
      REG_GRAD_COEF: prdata = grad_coef_q;
      default:       prdata = '0;
    endcase
  end

  gmeu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (dp_cmd)
  );

  gmeu_dp #(
    .PATCH_SIZE (PATCH_SIZE),
    .GHOST_SIZE (GHOST_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .use_pot_i    (use_pot_q),
    .five_point_i (five_pt_q),
    .ext_acc_en_i (ext_en_q),
    .time_step_i  (time_step_q),
    .grad_coef_i  (grad_coef_q),
    .pot_addr_i   (pot_addr_i),
    .pot_value_i  (pot_value_i),
    .cell_index_i (cell_index_i),
    .density_i    (density_i),
    .mom_x_in_i   (mom_x_in_i),
    .mom_y_in_i   (mom_y_in_i),
    .mom_z_in_i   (mom_z_in_i),
    .energy_in_i  (energy_in_i),
    .ext_acc_x_i  (ext_acc_x_i),
    .ext_acc_y_i  (ext_acc_y_i),
    .ext_acc_z_i  (ext_acc_z_i),
    .cell_out_o   (cell_out_o),
    .mom_x_out_o  (mom_x_out_o),
    .mom_y_out_o  (mom_y_out_o),
    .mom_z_out_o  (mom_z_out_o),
    .energy_out_o (energy_out_o)
  );

  // A cell item holds the input side until its result is handed off
  a_cell_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i |=> in_stall_o)
    else $error("input not held after a cell item");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.div_busy |-> in_stall_o)
    else $error("divider running while input side is open");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a cell item in progress");

endmodule

@@ sim/gravity_momentum_energy_update_tb.sv @@
// Self-checking testbench for the gravity momentum/energy update block.
`timescale 1ns / 100ps

module gravity_momentum_energy_update_tb;
  import gmeu_pkg::*;

  localparam int PATCH   = 8;
  localparam int GHOST   = 2;
  localparam int NXT     = PATCH + 2 * GHOST;
  localparam int DEPTH   = NXT * NXT * NXT;
  // Cells in the two lowest z layers; their stencils stay in the lowest store planes
  localparam int SLAB_CELLS  = 2 * PATCH * PATCH;
  localparam int SLAB_WORDS  = (2 * GHOST + 2) * NXT * NXT;
  localparam int WD_LIMIT   = 5000;
  localparam int DRAIN_WAIT = 80;
  localparam int HOLD_LEN   = 400;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CELL = 1'b1;

  typedef struct {
    logic [8:0]         idx;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic signed [31:0] en;
  } cell_update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [10:0] pot_addr_i = '0;
  logic signed [31:0] pot_value_i = '0;
  logic [8:0] cell_index_i = '0;
  logic [30:0] density_i = '0;
  logic signed [31:0] mom_x_in_i = '0, mom_y_in_i = '0, mom_z_in_i = '0, energy_in_i = '0;
  logic signed [31:0] ext_acc_x_i = '0, ext_acc_y_i = '0, ext_acc_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [8:0] cell_out_o;
  logic signed [31:0] mom_x_out_o, mom_y_out_o, mom_z_out_o, energy_out_o;

  gravity_momentum_energy_update #(.PATCH_SIZE(PATCH), .GHOST_SIZE(GHOST)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block's state and registers
  logic signed [31:0] pot_shadow [DEPTH];
  logic               cfg_use_pot = 1'b1;
  logic               cfg_five_pt = 1'b0;
  logic               cfg_ext_en  = 1'b0;
  logic signed [31:0] cfg_dt      = '0;
  logic signed [31:0] cfg_grad    = '0;

  cell_update_t cell_update_q [$];
  int  mismatches = 0;
  int  cells_sent = 0, loads_sent = 0, results_seen = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint pot_at(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= NXT || y >= NXT || z >= NXT) return 0;
    return longint'(pot_shadow[(z * NXT + y) * NXT + x]);
  endfunction

  function automatic longint kinetic_energy(longint unsigned hinv, longint p0, longint p1,
                                            longint p2);
    longint unsigned s, lo, hi, r, m0, m1, m2;
    m0 = (p0 < 0) ? -p0 : p0;
    m1 = (p1 < 0) ? -p1 : p1;
    m2 = (p2 < 0) ? -p2 : p2;
    s  = m0 * m0 + m1 * m1 + m2 * m2;
    lo = (s & 64'hFFFF_FFFF) * hinv;
    hi = (s >> 32) * hinv;
    r  = hi + ((lo + 64'h8000_0000) >> 32);
    if (r > 64'd2147483647) return 64'sd2147483647;
    return longint'(r);
  endfunction

  // Compute the expected update of one accepted cell item
  task automatic predict_cell();
    longint pin [3], pout [3], acc [3], ext [3];
    longint rho, p1, m1, p2, m2, diff, ek_in, ek_out;
    longint unsigned hinv;
    int ci, cx, cy, cz, d, dx, dy, dz;
    cell_update_t u;
    ci = int'(cell_index_i) % (PATCH * PATCH * PATCH);
    cx = ci % PATCH + GHOST;
    cy = ci / PATCH % PATCH + GHOST;
    cz = ci / (PATCH * PATCH) + GHOST;
    rho = longint'({1'b0, density_i});
    pin[0] = longint'(mom_x_in_i); pin[1] = longint'(mom_y_in_i);
    pin[2] = longint'(mom_z_in_i);
    ext[0] = longint'(ext_acc_x_i); ext[1] = longint'(ext_acc_y_i);
    ext[2] = longint'(ext_acc_z_i);
    for (d = 0; d < 3; d++) begin
      acc[d] = 0;
      if (cfg_ext_en) acc[d] = clamp32(qmul(cfg_dt, ext[d]));
      if (cfg_use_pot) begin
        dx = (d == 0); dy = (d == 1); dz = (d == 2);
        p1 = pot_at(cx + dx, cy + dy, cz + dz);
        m1 = pot_at(cx - dx, cy - dy, cz - dz);
        if (cfg_five_pt) begin
          p2 = pot_at(cx + 2 * dx, cy + 2 * dy, cz + 2 * dz);
          m2 = pot_at(cx - 2 * dx, cy - 2 * dy, cz - 2 * dz);
          diff = -p2 + 8 * p1 - 8 * m1 + m2;
        end else begin
          diff = p1 - m1;
        end
        diff = clamp32(diff);
        acc[d] = clamp32(acc[d] + clamp32(qmul(cfg_grad, diff)));
      end
    end
    if (rho == 0) begin
      hinv = 64'd2147483647;
    end else begin
      hinv = (64'h8000_0000 + longint'(rho) / 2) / longint'(rho);
      if (hinv > 64'd2147483647) hinv = 64'd2147483647;
    end
    for (d = 0; d < 3; d++) pout[d] = clamp32(pin[d] + qmul(rho, acc[d]));
    ek_in  = kinetic_energy(hinv, pin[0], pin[1], pin[2]);
    ek_out = kinetic_energy(hinv, pout[0], pout[1], pout[2]);
    u.idx = cell_index_i;
    u.mx = pout[0][31:0];
    u.my = pout[1][31:0];
    u.mz = pout[2][31:0];
    u.en = 32'(clamp32(longint'(energy_in_i) - ek_in + ek_out));
    cell_update_q.push_back(u);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(255) - 128;
      3: return ($urandom & 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and wait for its acceptance
  task automatic send_item(logic f, logic [10:0] addr, logic signed [31:0] pv, logic [8:0] ci,
                           logic [30:0] rho, logic signed [31:0] mx, logic signed [31:0] my,
                           logic signed [31:0] mz, logic signed [31:0] en,
                           logic signed [31:0] ax, logic signed [31:0] ay,
                           logic signed [31:0] az);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 8) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    func_i = f; pot_addr_i = addr; pot_value_i = pv; cell_index_i = ci; density_i = rho;
    mom_x_in_i = mx; mom_y_in_i = my; mom_z_in_i = mz; energy_in_i = en;
    ext_acc_x_i = ax; ext_acc_y_i = ay; ext_acc_z_i = az;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (f == FUNC_LOAD) begin
      loads_sent++;
      if (addr < DEPTH) pot_shadow[addr] = pv;
    end else begin
      cells_sent++;
      predict_cell();
    end
  endtask

  task automatic send_load(logic [10:0] addr, logic signed [31:0] pv);
    send_item(FUNC_LOAD, addr, pv, 9'($urandom), 31'($urandom), $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_cell(logic [8:0] ci, logic [30:0] rho, logic signed [31:0] mx,
                           logic signed [31:0] my, logic signed [31:0] mz,
                           logic signed [31:0] en, logic signed [31:0] ax,
                           logic signed [31:0] ay, logic signed [31:0] az);
    send_item(FUNC_CELL, 11'($urandom), $urandom, ci, rho, mx, my, mz, en, ax, ay, az);
  endtask

  task automatic send_random_cell();
    logic [30:0] rho;
    case ($urandom_range(4))
      0: rho = 31'($urandom_range(3));
      1: rho = 31'h7FFF_FFFF;
      2: rho = 31'($urandom_range(32'h0004_0000, 32'h0000_4000));
      default: rho = 31'($urandom);
    endcase
    send_cell(9'($urandom_range(SLAB_CELLS - 1)), rho, rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (cell_update_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_USE_POT:   cfg_use_pot = data[0];
      REG_FIVE_PT:   cfg_five_pt = data[0];
      REG_EXT_EN:    cfg_ext_en  = data[0];
      REG_TIME_STEP: cfg_dt      = data;
      REG_GRAD_COEF: cfg_grad    = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic up, logic fp, logic ee, logic [31:0] dt, logic [31:0] gc);
    wait_drained();
    apb_write(REG_USE_POT, {31'd0, up});
    apb_write(REG_FIVE_PT, {31'd0, fp});
    apb_write(REG_EXT_EN, {31'd0, ee});
    apb_write(REG_TIME_STEP, dt);
    apb_write(REG_GRAD_COEF, gc);
  endtask

  // Fill the lowest store planes so that no stencil read sees an unwritten word
  task automatic test_preload();
    int a;
    for (a = 0; a < SLAB_WORDS; a++) send_load(11'(a), rand_word());
  endtask

  task automatic test_directed();
    set_config(1'b1, 1'b0, 1'b1, 32'h0000_8000, 32'hFFFF_C000);
    send_load(11'd1728, 32'h1234_5678);  // beyond the store: dropped
    send_load(11'd2047, 32'h8000_0000);
    send_load(11'd0, 32'h7FFF_FFFF);
    send_cell(9'd0, 31'd0, 32'h0001_0000, -32'sd65536, 32'h0, 32'h0, 32'h0001_0000,
              32'h0001_0000, 32'h0001_0000);
    send_cell(9'd127, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cell(9'd1, 31'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cell(9'd73, 31'h0001_0000, 32'h0002_0000, 32'h0, -32'sd131072, 32'h0010_0000,
              32'h0, 32'h0, 32'h0);
    set_config(1'b1, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cell(9'd0, 31'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cell(9'd127, 31'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0, 32'h0, 32'h0, 32'h0);
    send_cell(9'd91, 31'd2, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    set_config(1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cell(9'd100, 31'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h0001_0000);
    send_cell(9'd200, 31'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h0);
    set_config(1'b0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_cell(9'd300, 31'h0003_0000, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000,
              32'h0100_0000, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random_phase(int n, bit quiet);
    int i;
    idle_on = !quiet;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(9) == 0) send_load(11'($urandom_range(2047, DEPTH)), $urandom);
        else send_load(11'($urandom_range(DEPTH - 1)), rand_word());
      end else begin
        send_random_cell();
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    set_config(1'b1, 1'b0, 1'b1, rand_word(), rand_word());
    test_random_phase(50, 1'b0);
    set_config(1'b1, 1'b1, 1'b1, rand_word(), rand_word());
    test_random_phase(50, 1'b1);
    set_config(1'b1, 1'b1, 1'b0, 32'h0000_0100, 32'hFFFF_FF00);
    test_random_phase(50, 1'b0);
    set_config(1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    test_random_phase(40, 1'b0);
    set_config(1'b1, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    test_random_phase(50, 1'b0);
  endtask

  // Hold the output long enough that the block backs up into its input
  task automatic test_backpressure();
    set_config(1'b1, 1'b1, 1'b1, rand_word(), rand_word());
    hold_req = 1'b1;
    test_random_phase(50, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_preload();
    test_directed();
    test_random();
    test_backpressure();
    wait_drained();
    $display("Run covered %0d cell items and %0d potential loads, %0d updates checked,",
             cells_sent, loads_sent, results_seen);
    $display("over stencil, external-kick and saturation settings with output back-pressure.");
    if (mismatches == 0 && cell_update_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output stall: random gaps, or one long hold on request
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = idle_on && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    cell_update_t u;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (cell_update_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected update for cell %0d", cell_out_o);
      end else begin
        u = cell_update_q.pop_front();
        if (u.idx !== cell_out_o || u.mx !== mom_x_out_o || u.my !== mom_y_out_o ||
            u.mz !== mom_z_out_o || u.en !== energy_out_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cell %0d mom %h %h %h en %h, got cell %0d mom %h %h %h en %h",
                     u.idx, u.mx, u.my, u.mz, u.en, cell_out_o, mom_x_out_o, mom_y_out_o,
                     mom_z_out_o, energy_out_o);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WD_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
